### design/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg
// shared types, codes and calibration constants of the sensor sample
// linearizer
// ----------------------------------------------------------------------------
package ssl_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int SERIES_W  = 16;
    localparam int VALUE_W   = 16;
    localparam int RES_W     = 32;
    localparam int RES_FRAC  = 8;
    localparam int CFG_IDX_W = 2;

    // sensor kinds
    typedef enum logic [2:0] {
        KIND_BOARD    = 3'd0,
        KIND_AIR      = 3'd1,
        KIND_PRESS    = 3'd2,
        KIND_MANIFOLD = 3'd3,
        KIND_SUP_3V3  = 3'd4,
        KIND_SUP_5V   = 3'd5,
        KIND_SUP_VIN  = 3'd6,
        KIND_INVALID  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SERIES_BOARD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SERIES_AIR   = CFG_IDX_W'(1);

    localparam logic [SERIES_W-1:0] SERIES_BOARD_RST = 16'd100;
    localparam logic [SERIES_W-1:0] SERIES_AIR_RST   = 16'd1000;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [1:0]          sensor_index;
        logic [SAMPLE_W-1:0] sample;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [RES_W-1:0]          resistance;
        logic [1:0]                status;
    } rsp_t;

    // side info that travels with every request down the pipeline
    typedef struct packed {
        kind_t                     kind;
        status_t                   status;
        logic signed [VALUE_W-1:0] value;
    } tag_t;

    // supply scale factors, hundredths of a volt at full scale
    localparam logic [10:0] SUP_C_3V3 = 11'd365;
    localparam logic [10:0] SUP_C_5V  = 11'd730;
    localparam logic [10:0] SUP_C_VIN = 11'd1630;

    // pressure, hundredths of a psi: round(s*PRESS_K / (F*PRESS_DIV))
    localparam longint PRESS_K    = 64'd10669854;
    localparam longint PRESS_LIM  = 64'd1000000;
    localparam longint PRESS_DIV  = 64'd689;
    localparam int     PRESS_X_W  = 24;
    localparam int     PRESS_SH   = PRESS_X_W + $clog2(PRESS_DIV);
    localparam int     PRESS_M_W  = PRESS_X_W + 1;
    localparam int     PRESS_Q_W  = PRESS_X_W + PRESS_M_W - PRESS_SH;
    localparam logic [PRESS_M_W-1:0] PRESS_M =
        PRESS_M_W'(((64'd1 << PRESS_SH) + PRESS_DIV - 64'd1) / PRESS_DIV);

    // manifold, hundredths of a bar: round(s*MANI_K / (F*MANI_DIV))
    localparam longint MANI_K    = 64'd659373;
    localparam longint MANI_LIM  = 64'd100000;
    localparam longint MANI_DIV  = 64'd1000;
    localparam int     MANI_X_W  = 20;
    localparam int     MANI_SH   = MANI_X_W + $clog2(MANI_DIV);
    localparam int     MANI_M_W  = MANI_X_W + 1;
    localparam int     MANI_Q_W  = MANI_X_W + MANI_M_W - MANI_SH;
    localparam logic [MANI_M_W-1:0] MANI_M =
        MANI_M_W'(((64'd1 << MANI_SH) + MANI_DIV - 64'd1) / MANI_DIV);

    // temperature segments: value = floor((A*256000 + 128000 - k*R) / 256000)
    localparam longint SEG_SCALE  = 64'd256000;
    localparam longint VAL_OFFSET = 64'd4096;
    localparam int     SEG_X_W    = 33;
    localparam int     SEG_SHIFT  = 11;
    localparam longint SEG_DIV    = SEG_SCALE >> SEG_SHIFT;
    localparam int     SEG_U_W    = SEG_X_W - SEG_SHIFT;
    localparam int     SEG_SH     = SEG_U_W + $clog2(SEG_DIV);
    localparam int     SEG_M_W    = SEG_U_W + 1;
    localparam int     SEG_Q_W    = SEG_U_W + SEG_M_W - SEG_SH;
    localparam logic [SEG_M_W-1:0] SEG_M =
        SEG_M_W'(((64'd1 << SEG_SH) + SEG_DIV - 64'd1) / SEG_DIV);
    localparam int     SLOPE_W    = 17;
    localparam int     RIN_W      = 24;

    // intercept term with rounding half and a positive offset folded in
    function automatic logic [SEG_X_W-1:0] seg_bias(input longint icpt);
        return SEG_X_W'(icpt * SEG_SCALE + SEG_SCALE / 2 + VAL_OFFSET * SEG_SCALE);
    endfunction

    // breakpoints in ohms: first lower bound (exclusive), inner bounds, upper bound
    localparam logic [15:0] SEG_BRK [0:1][0:5] = '{
        '{16'd27,  16'd68,  16'd120,  16'd224,  16'd438,  16'd950},
        '{16'd300, 16'd599, 16'd1268, 16'd3020, 16'd5830, 16'd62350}
    };

    localparam logic [SLOPE_W-1:0] SEG_SLOPE [0:1][0:4] = '{
        '{17'd83000, 17'd39000, 17'd19000, 17'd9000, 17'd4000},
        '{17'd11000, 17'd4500,  17'd1700,  17'd700,  17'd100}
    };

    localparam logic [SEG_X_W-1:0] SEG_BIAS [0:1][0:4] = '{
        '{seg_bias(17667), seg_bias(14615), seg_bias(12308), seg_bias(10093),
          seg_bias(7799)},
        '{seg_bias(18350), seg_bias(14686), seg_bias(11171), seg_bias(8150),
          seg_bias(4599)}
    };

endpackage

### design/sensor_sample_linearizer.sv
// ----------------------------------------------------------------------------
// sensor_sample_linearizer
// converts one raw adc sample of a sensor kind into engineering units
// ----------------------------------------------------------------------------
// a request is taken on every cycle that start is high; busy stays low, so
// one request per clock is sustained. each request gives exactly one result,
// shown for a single cycle with result_valid, in request order. the receiver
// cannot hold results off, and the pipeline never stalls. its depth is set
// by the divider for the temperature resistance, which resolves one
// quotient bit per stage over SAMPLE_W + 24 stages, followed by four stages
// of segment lookup, slope multiply and rounding. all other kinds are
// computed in a short side path and ride along to keep order.
// series resistor writes are always taken (cfg_ready is high); the series
// value is captured with each request, so a write affects later requests only.
// ----------------------------------------------------------------------------
module sensor_sample_linearizer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ssl_pkg::req_t                    request,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ssl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssl_pkg::SERIES_W-1:0]     cfg_data,
    output logic                             result_valid,
    output ssl_pkg::rsp_t                    result
);
    import ssl_pkg::*;

    localparam int SB     = SAMPLE_W;
    // numerator series*sample*256, one quotient bit per divider stage
    localparam int NUM_W  = RES_FRAC + SERIES_W + SAMPLE_W;
    // pipeline positions: input, product, divider, four table stages
    localparam int NPOS   = NUM_W + 6;
    localparam longint FULL = 64'd1 << SAMPLE_W;

    localparam logic [SB-1:0] PRESS_TH =
        SB'((FULL * PRESS_LIM + PRESS_K - 64'd1) / PRESS_K);
    localparam logic [SB-1:0] MANI_TH =
        SB'((FULL * MANI_LIM + MANI_K - 64'd1) / MANI_K);
    localparam logic [SB+PRESS_X_W-1:0] PRESS_HALF =
        (SB + PRESS_X_W)'(PRESS_DIV << (SAMPLE_W - 1));
    localparam logic [SB+MANI_X_W-1:0] MANI_HALF =
        (SB + MANI_X_W)'(MANI_DIV << (SAMPLE_W - 1));
    localparam logic [SB+10:0] SUP_HALF = (SB + 11)'(64'd1 << (SAMPLE_W - 1));

    // configuration registers
    logic [SERIES_W-1:0] series_board_reg;
    logic [SERIES_W-1:0] series_air_reg;

    // tag and valid travel together through every position
    tag_t tag_reg   [0:NPOS-1];
    tag_t tag_next  [0:NPOS-1];
    logic valid_reg [0:NPOS-1];

    // input position
    logic [SB-1:0]       s_reg;
    logic [SERIES_W-1:0] ser_reg;
    logic                bad_idx;

    // side path for pressure and supply kinds
    logic [SB+PRESS_X_W-1:0]           press_n_reg;
    logic                              press_low_reg;
    logic [SB+MANI_X_W-1:0]            mani_n_reg;
    logic                              mani_low_reg;
    logic [10:0]                       sup_c;
    logic [SB+10:0]                    sup_n;
    logic [PRESS_X_W+PRESS_M_W-1:0]    press_prod;
    logic [MANI_X_W+MANI_M_W-1:0]      mani_prod;
    logic [PRESS_Q_W-1:0]              press_q_reg;
    logic                              press_low2_reg;
    logic [MANI_Q_W-1:0]               mani_q_reg;
    logic                              mani_low2_reg;

    // divider stages
    logic [NUM_W-1:0] div_num_reg  [0:NUM_W];
    logic [SB-1:0]    div_rem_reg  [0:NUM_W-1];
    logic [SB:0]      div_d_reg    [0:NUM_W-1];
    logic [NUM_W-1:0] div_num_next [1:NUM_W];
    logic [SB-1:0]    div_rem_next [1:NUM_W-1];
    logic [SB:0]      div_trial    [1:NUM_W];
    logic [SB:0]      div_diff     [1:NUM_W];
    logic             div_ge       [1:NUM_W];

    // table stages
    logic [RES_W-1:0]              t1_res_next;
    logic [2:0]                    t1_seg_next;
    logic                          t1_in_next;
    logic                          t1_tbl;
    logic [RES_W-1:0]              t1_res_reg;
    logic [2:0]                    t1_seg_reg;
    logic                          t1_in_reg;
    logic                          t2_tbl;
    logic [SLOPE_W+RIN_W-1:0]      t2_prod;
    logic [RES_W-1:0]              t2_res_reg;
    logic [SEG_X_W-1:0]            t2_prod_reg;
    logic [SEG_X_W-1:0]            t2_bias_reg;
    logic                          t2_in_reg;
    logic [SEG_X_W-1:0]            t3_x;
    logic [RES_W-1:0]              t3_res_reg;
    logic [SEG_U_W-1:0]            t3_u_reg;
    logic                          t3_in_reg;
    logic [SEG_U_W+SEG_M_W-1:0]    t4_prod;
    logic [RES_W-1:0]              t4_res_reg;
    logic [SEG_Q_W-1:0]            t4_q_reg;
    logic                          t4_in_reg;

    // output register
    rsp_t result_next;
    rsp_t result_reg;
    logic result_valid_reg;
    tag_t out_tag;
    logic out_temp;

    assign busy         = 1'b0;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_board_reg <= SERIES_BOARD_RST;
            series_air_reg   <= SERIES_AIR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SERIES_BOARD: series_board_reg <= cfg_data;
                REG_SERIES_AIR:   series_air_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------- request check
    // sensor index limits per kind; kind 7 is always rejected
    always_comb
    begin
        case (kind_t'(request.req_type))
            KIND_AIR:      bad_idx = request.sensor_index >= 2'd3;
            KIND_PRESS:    bad_idx = request.sensor_index >= 2'd2;
            KIND_MANIFOLD: bad_idx = request.sensor_index >= 2'd1;
            KIND_INVALID:  bad_idx = 1'b1;
            default:       bad_idx = 1'b0;
        endcase
    end

    // supply scale by kind
    always_comb
    begin
        case (tag_reg[0].kind)
            KIND_SUP_3V3: sup_c = SUP_C_3V3;
            KIND_SUP_5V:  sup_c = SUP_C_5V;
            default:      sup_c = SUP_C_VIN;
        endcase
    end

    // supply volts: round(c*s/F), a multiply and a shift
    assign sup_n = (SB + 11)'(s_reg) * (SB + 11)'(sup_c) + SUP_HALF;

    // pressure quotients: divide by 2^SB with a shift, then by a constant
    // through a reciprocal multiply that is exact over the whole input range
    assign press_prod = (PRESS_X_W + PRESS_M_W)'(press_n_reg[SB+PRESS_X_W-1:SB])
                      * (PRESS_X_W + PRESS_M_W)'(PRESS_M);
    assign mani_prod  = (MANI_X_W + MANI_M_W)'(mani_n_reg[SB+MANI_X_W-1:SB])
                      * (MANI_X_W + MANI_M_W)'(MANI_M);

    // ---------------------------------------------------------------- tag path
    always_comb
    begin
        tag_next[0].kind   = kind_t'(request.req_type);
        tag_next[0].status = bad_idx ? ST_BAD : ST_OK;
        tag_next[0].value  = '0;
        for (int i = 1; i < NPOS; i++)
        begin
            tag_next[i] = tag_reg[i-1];
        end
        // supply kinds finish at the product position
        if ((tag_reg[0].kind == KIND_SUP_3V3) || (tag_reg[0].kind == KIND_SUP_5V)
            || (tag_reg[0].kind == KIND_SUP_VIN))
        begin
            tag_next[1].value = signed'(VALUE_W'(sup_n[SB+10:SB]));
        end
        // pressure kinds finish two positions later; zero below one bar
        if ((tag_reg[2].kind == KIND_PRESS) && (tag_reg[2].status == ST_OK))
        begin
            tag_next[3].value = press_low2_reg ? '0 : signed'(VALUE_W'(press_q_reg));
        end
        if ((tag_reg[2].kind == KIND_MANIFOLD) && (tag_reg[2].status == ST_OK))
        begin
            tag_next[3].value = mani_low2_reg ? '0 : signed'(VALUE_W'(mani_q_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NPOS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= start && !busy;
            for (int i = 1; i < NPOS; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NPOS; i++)
        begin
            tag_reg[i] <= tag_next[i];
        end
        // input position, series value picked by kind
        s_reg   <= SB'(request.sample);
        ser_reg <= (kind_t'(request.req_type) == KIND_AIR) ? series_air_reg
                                                           : series_board_reg;
        // product position
        press_n_reg   <= (SB + PRESS_X_W)'(s_reg) * (SB + PRESS_X_W)'(PRESS_K)
                       + PRESS_HALF;
        press_low_reg <= s_reg < PRESS_TH;
        mani_n_reg    <= (SB + MANI_X_W)'(s_reg) * (SB + MANI_X_W)'(MANI_K)
                       + MANI_HALF;
        mani_low_reg  <= s_reg < MANI_TH;
        // quotient position
        press_q_reg    <= press_prod[PRESS_X_W+PRESS_M_W-1:PRESS_SH];
        press_low2_reg <= press_low_reg;
        mani_q_reg     <= mani_prod[MANI_X_W+MANI_M_W-1:MANI_SH];
        mani_low2_reg  <= mani_low_reg;
    end

    // ---------------------------------------------------------------- divider
    // restoring division of series*s*256 by F-s, one bit per stage; the
    // numerator shifts out at the top while the quotient shifts in below
    always_comb
    begin
        for (int j = 1; j <= NUM_W; j++)
        begin
            div_trial[j]    = {div_rem_reg[j-1], div_num_reg[j-1][NUM_W-1]};
            div_ge[j]       = div_trial[j] >= div_d_reg[j-1];
            div_diff[j]     = div_trial[j] - div_d_reg[j-1];
            div_num_next[j] = {div_num_reg[j-1][NUM_W-2:0], div_ge[j]};
            if (j < NUM_W)
            begin
                div_rem_next[j] = div_ge[j] ? div_diff[j][SB-1:0]
                                            : div_trial[j][SB-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        div_num_reg[0] <= {(SERIES_W + SB)'(ser_reg) * (SERIES_W + SB)'(s_reg),
                           RES_FRAC'(0)};
        div_rem_reg[0] <= '0;
        div_d_reg[0]   <= (SB + 1)'(FULL) - (SB + 1)'(s_reg);
        for (int j = 1; j <= NUM_W; j++)
        begin
            div_num_reg[j] <= div_num_next[j];
        end
        for (int j = 1; j < NUM_W; j++)
        begin
            div_rem_reg[j] <= div_rem_next[j];
            div_d_reg[j]   <= div_d_reg[j-1];
        end
    end

    // ---------------------------------------------------------------- table
    // saturate to 32 bits, then find the segment
    always_comb
    begin
        t1_tbl      = tag_reg[NUM_W+1].kind == KIND_AIR;
        t1_res_next = ((div_num_reg[NUM_W] >> RES_W) != '0) ? '1
                                                            : RES_W'(div_num_reg[NUM_W]);
        t1_in_next  = (t1_res_next > RES_W'({SEG_BRK[t1_tbl][0], 8'h00}))
                   && (t1_res_next < RES_W'({SEG_BRK[t1_tbl][5], 8'h00}));
        t1_seg_next = '0;
        for (int i = 1; i < 5; i++)
        begin
            t1_seg_next = t1_seg_next
                        + 3'(t1_res_next >= RES_W'({SEG_BRK[t1_tbl][i], 8'h00}));
        end
    end

    assign t2_tbl  = tag_reg[NUM_W+2].kind == KIND_AIR;
    // inside the table the resistance stays below 2^24
    assign t2_prod = (SLOPE_W + RIN_W)'(SEG_SLOPE[t2_tbl][t1_seg_reg])
                   * (SLOPE_W + RIN_W)'(t1_res_reg[RIN_W-1:0]);
    assign t3_x    = t2_bias_reg - t2_prod_reg;
    // divide by 125 after the shift by 2048 through a reciprocal
    assign t4_prod = (SEG_U_W + SEG_M_W)'(t3_u_reg) * (SEG_U_W + SEG_M_W)'(SEG_M);

    always_ff @(posedge clk)
    begin
        t1_res_reg  <= t1_res_next;
        t1_seg_reg  <= t1_seg_next;
        t1_in_reg   <= t1_in_next;
        t2_res_reg  <= t1_res_reg;
        t2_prod_reg <= SEG_X_W'(t2_prod);
        t2_bias_reg <= SEG_BIAS[t2_tbl][t1_seg_reg];
        t2_in_reg   <= t1_in_reg;
        t3_res_reg  <= t2_res_reg;
        t3_u_reg    <= t3_x[SEG_X_W-1:SEG_SHIFT];
        t3_in_reg   <= t2_in_reg;
        t4_res_reg  <= t3_res_reg;
        t4_q_reg    <= t4_prod[SEG_U_W+SEG_M_W-1:SEG_SH];
        t4_in_reg   <= t3_in_reg;
    end

    // ---------------------------------------------------------------- output
    assign out_tag  = tag_reg[NPOS-1];
    assign out_temp = (out_tag.kind == KIND_BOARD) || (out_tag.kind == KIND_AIR);

    always_comb
    begin
        result_next.value      = out_tag.value;
        result_next.resistance = '0;
        result_next.status     = out_tag.status;
        if (out_temp && (out_tag.status != ST_BAD))
        begin
            result_next.resistance = t4_res_reg;
            if (t4_in_reg)
            begin
                // remove the offset that kept the rounding numerator positive
                result_next.value  = signed'(VALUE_W'(t4_q_reg) - VALUE_W'(VAL_OFFSET));
                result_next.status = ST_OK;
            end
            else
            begin
                result_next.value  = '0;
                result_next.status = ST_RANGE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= valid_reg[NPOS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

### sim/sensor_sample_linearizer_tb.sv
// ----------------------------------------------------------------------------
// sensor_sample_linearizer_tb
// drives sensor requests through the linearizer and checks every reading
// against an in-bench model of the conversion, over several series resistor
// settings, with random gaps on the request side
// ----------------------------------------------------------------------------
module sensor_sample_linearizer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ssl_pkg::*;

    localparam int RESET_CYCLES     = 11;
    localparam int PHASES           = 10;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int SETTLE_CYCLES    = 60;      // longer than the pipeline is deep
    localparam int CYCLE_LIMIT      = 500000;
    localparam int MAX_REPORTS      = 40;
    localparam longint FULL_SCALE   = 64'd4096;

    // calibration tables: breakpoints in ohms, intercepts in hundredths,
    // slopes in thousandths of a hundredth per ohm; row 0 board, row 1 air
    localparam longint TAB_BRK [0:1][0:5] = '{
        '{27, 68, 120, 224, 438, 950},
        '{300, 599, 1268, 3020, 5830, 62350}
    };
    localparam longint TAB_ICPT [0:1][0:4] = '{
        '{17667, 14615, 12308, 10093, 7799},
        '{18350, 14686, 11171, 8150, 4599}
    };
    localparam longint TAB_SLOPE [0:1][0:4] = '{
        '{83000, 39000, 19000, 9000, 4000},
        '{11000, 4500, 1700, 700, 100}
    };

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request side
    logic start   = 1'b0;
    logic busy;
    req_t request = '0;

    // series resistor write channel
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SERIES_W-1:0]  cfg_data  = '0;

    // reading side
    logic result_valid;
    rsp_t result;

    // bench copy of the series resistors, follows every accepted write
    logic [SERIES_W-1:0] series_board_m = SERIES_BOARD_RST;
    logic [SERIES_W-1:0] series_air_m   = SERIES_AIR_RST;

    req_t req_backlog[$];          // requests waiting for the driver
    rsp_t expected_readings[$];    // predicted readings, oldest first

    int hold_left       = 0;       // idle cycles before the next request
    int steady_left     = 0;       // requests left in a back-to-back burst
    int mismatch_count  = 0;
    int cycle_count     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sensor_sample_linearizer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // expected reading for one request under the current series resistors
    function automatic rsp_t linearize(input req_t rq);
        rsp_t            rd;
        kind_t           kind;
        longint unsigned s;
        longint unsigned ser;
        longint unsigned r;
        longint unsigned lo;
        longint unsigned hi;
        longint          val;
        longint          num;
        longint unsigned scale;
        bit              hit;
        bit              above;
        int              t;
        kind      = kind_t'(rq.req_type);
        s         = rq.sample;
        val       = 0;
        r         = 0;
        hit       = 1'b0;
        rd.status = ST_OK;
        case (kind)
            KIND_BOARD, KIND_AIR:
            begin
                t = (kind == KIND_AIR) ? 1 : 0;
                // board has four sensors, air only three
                if (kind == KIND_AIR && rq.sensor_index == 2'd3)
                begin
                    rd.status = ST_BAD;
                end
                else
                begin
                    ser = (t == 1) ? series_air_m : series_board_m;
                    r   = ser * 256 * s / (FULL_SCALE - s);
                    if (r > 64'hFFFF_FFFF)
                        r = 64'hFFFF_FFFF;
                    for (int i = 0; i < 5; i++)
                    begin
                        lo    = TAB_BRK[t][i] * 256;
                        hi    = TAB_BRK[t][i+1] * 256;
                        // only the first segment has an open lower end
                        above = (i == 0) ? (r > lo) : (r >= lo);
                        if (!hit && above && r < hi)
                        begin
                            hit = 1'b1;
                            num = TAB_ICPT[t][i] * 256000
                                  - TAB_SLOPE[t][i] * longint'(r) + 128000;
                            // floor division, halves round up
                            val = num / 256000;
                            if (num < 0 && val * 256000 != num)
                                val = val - 1;
                        end
                    end
                    if (!hit)
                    begin
                        val       = 0;
                        rd.status = ST_RANGE;
                    end
                end
            end
            KIND_PRESS:
            begin
                scale = FULL_SCALE * 689;
                if (rq.sensor_index >= 2'd2)
                    rd.status = ST_BAD;
                else if (s * 10669854 >= FULL_SCALE * 1000000)
                    val = longint'((s * 10669854 + scale / 2) / scale);
            end
            KIND_MANIFOLD:
            begin
                scale = FULL_SCALE * 1000;
                if (rq.sensor_index != 2'd0)
                    rd.status = ST_BAD;
                else if (s * 659373 >= FULL_SCALE * 100000)
                    val = longint'((s * 659373 + scale / 2) / scale);
            end
            KIND_SUP_3V3:
                val = longint'((365 * s + FULL_SCALE / 2) / FULL_SCALE);
            KIND_SUP_5V:
                val = longint'((730 * s + FULL_SCALE / 2) / FULL_SCALE);
            KIND_SUP_VIN:
                val = longint'((1630 * s + FULL_SCALE / 2) / FULL_SCALE);
            default:
                rd.status = ST_BAD;
        endcase
        if (val > 32767)
            val = 32767;
        else if (val < -32768)
            val = -32768;
        rd.value      = val[VALUE_W-1:0];
        rd.resistance = r[RES_W-1:0];
        return rd;
    endfunction

    // random request, biased toward samples that land inside the tables
    function automatic req_t random_item();
        req_t        rq;
        kind_t       kind;
        int unsigned pick;
        int          t;
        longint      ser;
        longint      r_ohm;
        longint      s;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            kind = KIND_BOARD;
        else if (pick < 60)
            kind = KIND_AIR;
        else
            kind = kind_t'($urandom_range(2, 7));
        rq.req_type     = kind;
        rq.sensor_index = 2'($urandom_range(0, 3));
        // mostly a legal sensor of the kind, now and then any index
        if ($urandom_range(0, 9) != 0)
        begin
            case (kind)
                KIND_AIR:      rq.sensor_index = 2'($urandom_range(0, 2));
                KIND_PRESS:    rq.sensor_index = 2'($urandom_range(0, 1));
                KIND_MANIFOLD: rq.sensor_index = 2'd0;
                default: ;
            endcase
        end
        pick = $urandom_range(0, 99);
        if ((kind == KIND_BOARD || kind == KIND_AIR) && pick < 60)
        begin
            // aim at a resistance inside the table, often right at a breakpoint
            t   = (kind == KIND_AIR) ? 1 : 0;
            ser = (t == 1) ? series_air_m : series_board_m;
            if (pick < 25)
                r_ohm = TAB_BRK[t][$urandom_range(0, 5)];
            else
                r_ohm = longint'($urandom_range(TAB_BRK[t][0], TAB_BRK[t][5]));
            s = (FULL_SCALE * r_ohm + (ser + r_ohm) / 2) / (ser + r_ohm)
                + longint'($urandom_range(0, 4)) - 2;
        end
        else if (kind == KIND_PRESS && pick < 40)
            s = longint'($urandom_range(374, 394));     // around one bar
        else if (kind == KIND_MANIFOLD && pick < 40)
            s = longint'($urandom_range(611, 632));     // around one bar
        else if (pick < 75)
            s = ($urandom_range(0, 1) == 1) ? longint'($urandom_range(0, 15))
                                            : longint'($urandom_range(4080, 4095));
        else
            s = longint'($urandom_range(0, 4095));
        if (s < 0)
            s = 0;
        else if (s > 4095)
            s = 4095;
        rq.sample = s[SAMPLE_W-1:0];
        return rq;
    endfunction

    // idle gap before the next request: mostly none, some short, a few long,
    // with occasional back-to-back bursts
    function automatic int idle_cycles();
        int unsigned pick;
        if (steady_left != 0)
        begin
            steady_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            steady_left = $urandom_range(20, 80);
            return 0;
        end
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_req(input kind_t kind, input logic [1:0] idx,
                                    input logic [SAMPLE_W-1:0] smp);
        req_t rq;
        rq.req_type     = kind;
        rq.sensor_index = idx;
        rq.sample       = smp;
        req_backlog.push_back(rq);
    endfunction

    task automatic flag_mismatch(input string what, input longint got,
                                 input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %0d expected %0d",
                     $time, what, got, want);
    endtask

    // one series resistor write; ends once cfg_valid is sampled low after the
    // handshake, so that back-to-back writes never touch it twice in one step
    task automatic write_series(input logic [CFG_IDX_W-1:0] idx,
                                input logic [SERIES_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SERIES_BOARD: series_board_m = data;
            REG_SERIES_AIR:   series_air_m   = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // sender holds off until every request has been issued and answered;
    // the quiet check must pass on consecutive edges, since the driver may pop
    // the last request on the same edge that is checked here
    task automatic wait_drained();
        int quiet;
        quiet = 0;
        while (quiet < 2)
        begin
            @(posedge clk);
            if (req_backlog.size() != 0 || start || expected_readings.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    // driver: a request is taken on an edge with start high and busy low;
    // the prediction is made then, with the series values of that moment
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_readings.push_back(linearize(request));
            if (!start || !busy)
            begin
                if (hold_left != 0)
                begin
                    hold_left--;
                    start <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    request   <= req_backlog.pop_front();
                    start     <= 1'b1;
                    hold_left = idle_cycles();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed reading must match the oldest prediction
    always @(posedge clk)
    begin : reading_check
        rsp_t want;
        if (rst_n && result_valid)
        begin
            if (expected_readings.size() == 0)
            begin
                flag_mismatch("reading with no request pending",
                              longint'(result.value), 0);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (result.value !== want.value)
                    flag_mismatch("value", longint'(result.value),
                                  longint'(want.value));
                if (result.resistance !== want.resistance)
                    flag_mismatch("resistance", longint'(result.resistance),
                                  longint'(want.resistance));
                if (result.status !== want.status)
                    flag_mismatch("status", longint'(result.status),
                                  longint'(want.status));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sensor_sample_linearizer_tb: errors");
            $finish;
        end
    end

    // stimulus sequencer
    initial
    begin
        logic [SERIES_W-1:0] board_set;
        logic [SERIES_W-1:0] air_set;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed pass under reset values: board 100 ohm, air 1000 ohm
        add_req(KIND_BOARD, 2'd0, 12'd0);        // zero sample falls off the table
        add_req(KIND_BOARD, 2'd1, 12'd1000);     // first board segment
        add_req(KIND_BOARD, 2'd2, 12'd2048);     // 100 ohm
        add_req(KIND_BOARD, 2'd3, 12'd2500);
        add_req(KIND_BOARD, 2'd0, 12'd3000);
        add_req(KIND_BOARD, 2'd1, 12'd3500);     // last board segment
        add_req(KIND_BOARD, 2'd2, 12'd3800);     // above the board table
        add_req(KIND_BOARD, 2'd3, 12'd4095);
        add_req(KIND_AIR, 2'd0, 12'd500);        // below the air table
        add_req(KIND_AIR, 2'd1, 12'd1000);
        add_req(KIND_AIR, 2'd2, 12'd2048);       // 1000 ohm exactly
        add_req(KIND_AIR, 2'd0, 12'd3300);
        add_req(KIND_AIR, 2'd1, 12'd4000);
        add_req(KIND_AIR, 2'd3, 12'd2048);       // no fourth air sensor
        add_req(KIND_PRESS, 2'd0, 12'd0);        // below one bar clamps to zero
        add_req(KIND_PRESS, 2'd1, 12'd383);
        add_req(KIND_PRESS, 2'd0, 12'd384);      // first sample at one bar
        add_req(KIND_PRESS, 2'd1, 12'd4095);
        add_req(KIND_PRESS, 2'd2, 12'd2000);     // bad index
        add_req(KIND_MANIFOLD, 2'd0, 12'd621);
        add_req(KIND_MANIFOLD, 2'd0, 12'd622);
        add_req(KIND_MANIFOLD, 2'd0, 12'd4095);
        add_req(KIND_MANIFOLD, 2'd1, 12'd2000);  // single manifold sensor
        add_req(KIND_SUP_3V3, 2'd3, 12'd4095);   // index ignored on supplies
        add_req(KIND_SUP_5V, 2'd0, 12'd2048);
        add_req(KIND_SUP_VIN, 2'd2, 12'd4095);
        add_req(KIND_INVALID, 2'd0, 12'd1234);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin board_set = 16'd1;     air_set = 16'd1;     end
                1:       begin board_set = 16'd65535; air_set = 16'd65535; end
                2:       begin board_set = 16'd1;     air_set = 16'd65535; end
                3:       begin board_set = 16'd65535; air_set = 16'd1;     end
                4:       begin board_set = 16'd100;   air_set = 16'd1000;  end
                default:
                begin
                    board_set = 16'($urandom_range(1, 65535));
                    air_set   = 16'($urandom_range(1, 65535));
                end
            endcase
            // block is idle here, so the new values apply to all later requests
            write_series(REG_SERIES_BOARD, board_set);
            write_series(REG_SERIES_AIR, air_set);

            // top and bottom of the sample range under this setting,
            // the top one saturates the resistance with a large resistor
            add_req(KIND_BOARD, 2'd0, 12'd4095);
            add_req(KIND_AIR, 2'd1, 12'd4095);
            add_req(KIND_AIR, 2'd2, 12'd0);
            repeat (RANDOM_PER_PHASE) req_backlog.push_back(random_item());
            wait_drained();
        end

        // let any stray reading show up before judging
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("sensor_sample_linearizer_tb: clean");
        else
            $display("sensor_sample_linearizer_tb: errors");
        $finish;
    end

endmodule
